[src/hufd_pkg.sv]
// Package for the Huffman tree bit decoder.
// Holds sizes, command and state types shared by the front, queue and back.
// Depends on nothing.
package hufd_pkg;

   localparam int NODE_COUNT       = 512;
   localparam int NODE_W           = $clog2(NODE_COUNT);
   localparam int MAX_SYMBOL_BYTES = 2;
   localparam int SYM_IDX_W        = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;
   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 2;
   localparam int BITS_W           = 4;
   localparam int BITS_MAX         = 8;
   localparam int PARENT_W         = 10;
   localparam int COUNT_W          = 24;
   localparam int ACTION_W         = 2;
   localparam int REQ_DATA_W       = 56;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_START  = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_DECODE = 2'd2
   } action_type;

   typedef logic [MAX_SYMBOL_BYTES-1:0][BYTE_W-1:0] sym_bytes_type;

   typedef struct packed {
      action_type          kind;
      logic [NODE_W-1:0]   node;
      logic                link_ok;
      logic [NODE_W-1:0]   parent;
      logic                is_right;
      logic [LEN_W-1:0]    len;
      sym_bytes_type       syms;
      logic [BYTE_W-1:0]   data;
      logic [BITS_W-1:0]   bits;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_EMIT,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic clearing;
      logic idle;
      logic pend_valid;
   } stat_type;

endpackage

[src/hufd_front.sv]
// Front end of the Huffman tree bit decoder: accepts request transactions,
// classifies them and pushes normalized commands. Depends on hufd_pkg.
module hufd_front
   import hufd_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ACTION_W-1:0]   req_tuser,   // action
   // node_index, parent_index, is_right, symbol_len, symbol_first,
   // symbol_second, data_byte, bits_in_byte, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   localparam int NODE_LSB   = 0;
   localparam int PARENT_LSB = NODE_LSB + NODE_W;
   localparam int RIGHT_LSB  = PARENT_LSB + PARENT_W;
   localparam int LEN_LSB    = RIGHT_LSB + 1;
   localparam int SYM0_LSB   = LEN_LSB + LEN_W;
   localparam int SYM1_LSB   = SYM0_LSB + BYTE_W;
   localparam int DATA_LSB   = SYM1_LSB + BYTE_W;
   localparam int BITS_LSB   = DATA_LSB + BYTE_W;

   logic [PARENT_W-1:0] parent_raw;
   logic [LEN_W-1:0]    len_raw;
   logic [BITS_W-1:0]   bits_raw;
   logic                keep;

   assign parent_raw = req_tdata[PARENT_LSB +: PARENT_W];
   assign len_raw    = req_tdata[LEN_LSB +: LEN_W];
   assign bits_raw   = req_tdata[BITS_LSB +: BITS_W];

   always_comb begin
      q_cmd          = '0;
      keep           = 1'b0;
      q_cmd.node     = req_tdata[NODE_LSB +: NODE_W];
      q_cmd.parent   = parent_raw[NODE_W-1:0];
      // Negative parents have the top bit set and fail this compare too.
      q_cmd.link_ok  = parent_raw < PARENT_W'(NODE_COUNT);
      q_cmd.is_right = req_tdata[RIGHT_LSB];
      q_cmd.len      = (len_raw > LEN_W'(MAX_SYMBOL_BYTES)) ?
                       LEN_W'(MAX_SYMBOL_BYTES) : len_raw;
      q_cmd.syms[0]  = req_tdata[SYM0_LSB +: BYTE_W];
      if (MAX_SYMBOL_BYTES > 1) begin
         q_cmd.syms[MAX_SYMBOL_BYTES-1] = req_tdata[SYM1_LSB +: BYTE_W];
      end
      q_cmd.data     = req_tdata[DATA_LSB +: BYTE_W];
      q_cmd.bits     = (bits_raw > BITS_W'(BITS_MAX)) ? BITS_W'(BITS_MAX) : bits_raw;
      unique case (req_tuser)
         ACT_START: begin
            keep       = 1'b1;
            q_cmd.kind = ACT_START;
         end
         ACT_WRITE: begin
            keep       = 1'b1;
            q_cmd.kind = ACT_WRITE;
         end
         ACT_DECODE: begin
            // A decode with no valid bits has no effect at all.
            keep       = bits_raw != '0;
            q_cmd.kind = ACT_DECODE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;

endmodule

[src/hufd_cmd_queue.sv]
// Short command queue between the front and the back of the decoder.
// Depends on hufd_pkg.
module hufd_cmd_queue
   import hufd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/hufd_back.sv]
// Back end of the decoder: node table memories, link clearing sweep, tree walk,
// symbol emission and the result register. Depends on hufd_pkg.
module hufd_back
   import hufd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast,
   output stat_type           stat
);

   logic [NODE_W-1:0] left_mem  [NODE_COUNT];
   logic [NODE_W-1:0] right_mem [NODE_COUNT];
   logic [LEN_W-1:0]  len_mem   [NODE_COUNT];
   sym_bytes_type     sym_mem   [NODE_COUNT];

   back_state_type     state_ff, state_in;
   logic [NODE_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clear_len_ff, clear_len_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               halted_ff, halted_in;
   logic [COUNT_W-1:0] max_ff, max_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [BITS_W-1:0]  step_ff, step_in;
   logic               check_ff, check_in;
   logic [SYM_IDX_W-1:0] idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0]  pend_byte_ff, pend_byte_in;
   logic               pend_status_ff, pend_status_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;

   logic [NODE_W-1:0]  rd_left_ff, rd_right_ff;
   logic [LEN_W-1:0]   rd_len_ff;
   sym_bytes_type      rd_sym_ff;

   logic               rd_en;
   logic [NODE_W-1:0]  rd_addr;
   logic               lw_left, lw_right;
   logic [NODE_W-1:0]  lw_addr, lw_data;
   logic               len_we, sym_we;
   logic [NODE_W-1:0]  nw_addr;
   logic [LEN_W-1:0]   nw_len;

   logic               out_free;
   logic               leaf;
   logic               more_bits;
   logic [NODE_W-1:0]  next_node;
   logic               last_sym;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign leaf      = (rd_left_ff == '0) && (rd_right_ff == '0);
   assign more_bits = step_ff < bits_ff;
   assign next_node = data_ff[BYTE_W-1] ? rd_right_ff : rd_left_ff;
   assign last_sym  = (LEN_W'(idx_ff) + LEN_W'(1)) == rd_len_ff;

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      clear_len_in   = clear_len_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      halted_in      = halted_ff;
      max_in         = csr_wen ? csr_wdata : max_ff;
      data_in        = data_ff;
      bits_in        = bits_ff;
      step_in        = step_ff;
      check_in       = check_ff;
      idx_in         = idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_byte_in   = pend_byte_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_byte_in    = out_byte_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      q_pop          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      lw_left        = 1'b0;
      lw_right       = 1'b0;
      lw_addr        = q_cmd.parent;
      lw_data        = q_cmd.node;
      len_we         = 1'b0;
      sym_we         = 1'b0;
      nw_addr        = q_cmd.node;
      nw_len         = q_cmd.len;

      unique case (state_ff)
         ST_CLEAR: begin
            lw_left  = 1'b1;
            lw_right = 1'b1;
            lw_addr  = clr_cnt_ff;
            lw_data  = '0;
            len_we   = clear_len_ff;
            nw_addr  = clr_cnt_ff;
            nw_len   = '0;
            if (clr_cnt_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + NODE_W'(1);
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  ACT_START: begin
                     state_in     = ST_CLEAR;
                     clr_cnt_in   = '0;
                     clear_len_in = 1'b0;
                     cur_in       = '0;
                     count_in     = '0;
                     halted_in    = 1'b0;
                  end
                  ACT_WRITE: begin
                     len_we   = 1'b1;
                     sym_we   = 1'b1;
                     lw_left  = q_cmd.link_ok && !q_cmd.is_right;
                     lw_right = q_cmd.link_ok && q_cmd.is_right;
                  end
                  ACT_DECODE: begin
                     if (!halted_ff) begin
                        data_in  = q_cmd.data;
                        bits_in  = q_cmd.bits;
                        step_in  = '0;
                        check_in = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = cur_ff;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            check_in = 1'b0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (check_ff && leaf) begin
               cur_in = '0;
               if (rd_len_ff != '0) begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else if (more_bits) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  check_in = 1'b0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (more_bits) begin
               cur_in   = next_node;
               rd_en    = 1'b1;
               rd_addr  = next_node;
               data_in  = {data_ff[BYTE_W-2:0], 1'b0};
               step_in  = step_ff + BITS_W'(1);
               check_in = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_byte_in   = pend_byte_ff;
                  out_status_in = pend_status_ff;
                  out_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               if (count_ff >= max_ff) begin
                  pend_byte_in   = '0;
                  pend_status_in = 1'b1;
                  halted_in      = 1'b1;
                  state_in       = ST_FINISH;
               end else begin
                  pend_byte_in   = rd_sym_ff[idx_ff];
                  pend_status_in = 1'b0;
                  count_in       = count_ff + COUNT_W'(1);
                  if (last_sym) begin
                     state_in = more_bits ? ST_LOAD : ST_FINISH;
                  end else begin
                     idx_in = idx_ff + SYM_IDX_W'(1);
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = pend_byte_ff;
               out_status_in = pend_status_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clear_len_ff  <= 1'b1;
         cur_ff        <= '0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         max_ff        <= '1;
         check_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clear_len_ff  <= clear_len_in;
         cur_ff        <= cur_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         max_ff        <= max_in;
         check_ff      <= check_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff        <= data_in;
      bits_ff        <= bits_in;
      step_ff        <= step_in;
      idx_ff         <= idx_in;
      pend_byte_ff   <= pend_byte_in;
      pend_status_ff <= pend_status_in;
      out_byte_ff    <= out_byte_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (lw_left) begin
         left_mem[lw_addr] <= lw_data;
      end
      if (lw_right) begin
         right_mem[lw_addr] <= lw_data;
      end
      if (len_we) begin
         len_mem[nw_addr] <= nw_len;
      end
      if (sym_we) begin
         sym_mem[nw_addr] <= q_cmd.syms;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_left_ff  <= left_mem[rd_addr];
         rd_right_ff <= right_mem[rd_addr];
         rd_len_ff   <= len_mem[rd_addr];
         rd_sym_ff   <= sym_mem[rd_addr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   assign stat.clearing   = state_ff == ST_CLEAR;
   assign stat.idle       = state_ff == ST_IDLE;
   assign stat.pend_valid = pend_valid_ff;

endmodule

[src/huffman_tree_bit_decoder.sv]
// Huffman tree bit decoder top level: front end, command queue and back end; uses hufd_pkg.
// A decode transaction loads the current node, steps once per data bit, checks the last node
// and closes; a leaf with symbols emits its bytes in order and then reloads the root when bits
// remain, a leaf without symbols rereads the root when bits remain, and output stalls hold it.
// A node write is done by the back end from idle; a start sweeps all 512 link table entries.
// Synchronous active-high reset starts a sweep of all 512 links and symbol lengths.
module huffman_tree_bit_decoder
   import hufd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ACTION_W-1:0]   req_tuser,   // action
   // node_index, parent_index, is_right, symbol_len, symbol_first,
   // symbol_second, data_byte, bits_in_byte, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,   // out_byte
   output logic                  rsp_tuser,   // status
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   cmd_type  push_cmd;
   cmd_type  pop_cmd;
   stat_type stat;

   hufd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   hufd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   hufd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .stat       (stat)
   );

   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && rsp_tlast)
      else $error("Full status must carry a zero byte and close the transaction.");

   a_sweep_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> stat.clearing)
      else $error("Link sweep did not start after reset.");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      stat.idle |-> !stat.pend_valid)
      else $error("Back end went idle with a result still pending.");

endmodule
